@@ rtl/sui_pkg.sv @@
// Shared types and constants for the sorted unique insert list.
package sui_pkg;

	localparam int ENTRY_W  = 15;
	localparam int VALUE_W  = 16;
	localparam int ACTION_W = 2;
	localparam int STATUS_W = 3;

	typedef logic [ENTRY_W-1:0] entry_t;

	typedef enum logic [ACTION_W-1:0] {
		ACT_INSERT = 2'd0,
		ACT_DRAIN  = 2'd1,
		ACT_CLEAR  = 2'd2
	} action_t;

	typedef enum logic [STATUS_W-1:0] {
		ST_INSERTED = 3'd0,
		ST_IGNORED  = 3'd1,
		ST_FULL     = 3'd2,
		ST_DRAINED  = 3'd3,
		ST_EMPTY    = 3'd4
	} status_t;

	// Command broadcast to every cell of the chain
	typedef enum logic [1:0] {
		OP_HOLD,
		OP_INSERT,
		OP_SHIFT_DN,
		OP_CLEAR
	} cell_op_t;

	typedef struct packed {
		cell_op_t op;
		entry_t   value;
	} cell_cmd_t;

	// What a cell shows its neighbors
	typedef struct packed {
		logic   valid;
		logic   take;   // cell sits at or above the insert point
		entry_t data;
	} cell_link_t;

	typedef enum logic {
		S_IDLE,
		S_DRAIN
	} state_t;

endpackage

@@ rtl/sui_if.sv @@
// Valid/ready channel interfaces for the input and result streams.
interface sui_in_if;
	logic                          valid;
	logic                          ready;
	logic [sui_pkg::ACTION_W-1:0]  action;
	logic signed [sui_pkg::VALUE_W-1:0] value;

	modport source (output valid, output action, output value, input ready);
	modport sink   (input valid, input action, input value, output ready);
endinterface

interface sui_out_if;
	logic                          valid;
	logic                          ready;
	logic [sui_pkg::ENTRY_W-1:0]   entry;
	logic                          last;
	logic [sui_pkg::STATUS_W-1:0]  status;

	modport source (output valid, output entry, output last, output status, input ready);
	modport sink   (input valid, input entry, input last, input status, output ready);
endinterface

@@ rtl/sorted_unique_insert_list.sv @@
// Top level of the sorted unique insert list: cell chain, control and result register.
//
//  channel  | modport | payload                    | transfers
//  ---------+---------+----------------------------+---------------------------------
//  in_ch    | sink    | action[1:0], value[15:0] s | one per item
//  out_ch   | source  | entry[14:0], last, status  | one per item, entry count on drain
//
//  Insert, clear, unused codes and a drain of an empty list finish in the transfer cycle
//  with one result. A drain of a non-empty list moves to S_DRAIN in the transfer cycle,
//  then one entry leaves cell 0 per cycle while out_ch is not stalled and the chain
//  shifts down; in_ch is held off until the last entry is registered.
//  A result register sits on out_ch; a new item is taken while it is being emptied.
//  out_ch stalls hold off in_ch once the result register is full and pause a drain;
//  nothing is lost. arst_n empties the list.
module sorted_unique_insert_list #(
	parameter int CAPACITY = 32
) (
	input  logic           clk,
	input  logic           arst_n,
	sui_in_if.sink         in_ch,
	sui_out_if.source      out_ch
);
	import sui_pkg::*;

	// Chain of cells; cell 0 holds the smallest entry
	cell_cmd_t        cmd;
	cell_link_t       links [CAPACITY];
	logic [CAPACITY-1:0] valid_vec;
	logic [CAPACITY-1:0] eq_vec;

	localparam cell_link_t BOTTOM_LINK = '{valid: 1'b1, take: 1'b0, data: '0};
	localparam cell_link_t TOP_LINK    = '{valid: 1'b0, take: 1'b0, data: '0};

	for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
		cell_link_t lo_link;
		cell_link_t hi_link;

		if (i == 0) begin : g_lo_end
			assign lo_link = BOTTOM_LINK;
		end else begin : g_lo
			assign lo_link = links[i-1];
		end

		if (i == CAPACITY-1) begin : g_hi_end
			assign hi_link = TOP_LINK;
		end else begin : g_hi
			assign hi_link = links[i+1];
		end

		sui_cell u_cell (
			.clk    (clk),
			.arst_n (arst_n),
			.cmd    (cmd),
			.lo     (lo_link),
			.hi     (hi_link),
			.link   (links[i]),
			.eq     (eq_vec[i])
		);

		assign valid_vec[i] = links[i].valid;
	end

	// Control
	state_t  state_q, state_d;
	logic    out_valid_q;
	entry_t  out_entry_q;
	logic    out_last_q;
	status_t out_status_q;

	logic    slot_free;
	logic    accept;
	logic    value_pos;
	logic    dup;
	logic    full;
	logic    load;
	entry_t  ld_entry;
	logic    ld_last;
	status_t ld_status;

	assign slot_free   = !out_valid_q || out_ch.ready;
	assign in_ch.ready = (state_q == S_IDLE) && slot_free;
	assign accept      = in_ch.valid && in_ch.ready;

	// Only values of 1 and up are stored
	assign value_pos = !in_ch.value[VALUE_W-1] && (in_ch.value[ENTRY_W-1:0] != '0);
	assign dup       = |(eq_vec & valid_vec);
	assign full      = valid_vec[CAPACITY-1];

	always_comb begin
		state_d   = state_q;
		cmd.op    = OP_HOLD;
		cmd.value = in_ch.value[ENTRY_W-1:0];
		load      = 1'b0;
		ld_entry  = '0;
		ld_last   = 1'b1;
		ld_status = ST_IGNORED;

		case (state_q)
			S_IDLE: begin
				if (accept) begin
					load = 1'b1;
					case (action_t'(in_ch.action))
						ACT_INSERT: begin
							// duplicate check comes before the full check
							if (!value_pos || dup) begin
								ld_status = ST_IGNORED;
							end else if (full) begin
								ld_status = ST_FULL;
							end else begin
								cmd.op    = OP_INSERT;
								ld_status = ST_INSERTED;
							end
						end
						ACT_DRAIN: begin
							if (!valid_vec[0]) begin
								ld_status = ST_EMPTY;
							end else begin
								load    = 1'b0;
								state_d = S_DRAIN;
							end
						end
						ACT_CLEAR: begin
							cmd.op    = OP_CLEAR;
							ld_status = ST_EMPTY;
						end
						default: begin
							ld_status = ST_IGNORED;
						end
					endcase
				end
			end
			S_DRAIN: begin
				if (slot_free) begin
					load      = 1'b1;
					ld_entry  = links[0].data;
					ld_last   = !valid_vec[1];
					ld_status = ST_DRAINED;
					cmd.op    = OP_SHIFT_DN;
					if (!valid_vec[1]) begin
						state_d = S_IDLE;
					end
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (load) begin
				out_valid_q <= 1'b1;
			end else if (out_ch.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			out_entry_q  <= ld_entry;
			out_last_q   <= ld_last;
			out_status_q <= ld_status;
		end
	end

	assign out_ch.valid  = out_valid_q;
	assign out_ch.entry  = out_entry_q;
	assign out_ch.last   = out_last_q;
	assign out_ch.status = out_status_q;

	// Occupied cells always form a contiguous run from cell 0
	a_contiguous: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_vec[CAPACITY-1:1] & ~valid_vec[CAPACITY-2:0]) == '0)
		else $error("hole in occupied cells");

	// A successful insert grows the list by exactly one
	a_insert_grows: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.op == OP_INSERT) |=>
		($countones(valid_vec) == $past($countones(valid_vec)) + 1))
		else $error("insert did not add one entry");

	// After the final drained entry the list is empty
	a_drain_empties: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_DRAIN && load && ld_last) |=> (valid_vec == '0))
		else $error("list not empty after drain");

	// No new item is taken while a drain is running
	a_drain_blocks: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_DRAIN && !(load && ld_last)) |=> !in_ch.ready)
		else $error("input taken during drain");

endmodule

@@ rtl/sui_cell.sv @@
// One compare-and-shift cell of the sorted list chain.
module sui_cell (
	input  logic               clk,
	input  logic               arst_n,
	input  sui_pkg::cell_cmd_t  cmd,
	input  sui_pkg::cell_link_t lo,    // neighbor one place lower
	input  sui_pkg::cell_link_t hi,    // neighbor one place higher
	output sui_pkg::cell_link_t link,
	output logic               eq
);
	import sui_pkg::*;

	logic   valid_q;
	entry_t data_q;
	logic   take;

	assign take = !valid_q || (data_q > cmd.value);
	assign eq   = valid_q && (data_q == cmd.value);

	assign link.valid = valid_q;
	assign link.take  = take;
	assign link.data  = data_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else begin
			case (cmd.op)
				OP_INSERT:   valid_q <= valid_q | lo.valid;
				OP_SHIFT_DN: valid_q <= hi.valid;
				OP_CLEAR:    valid_q <= 1'b0;
				default:     valid_q <= valid_q;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (cmd.op)
			OP_INSERT: begin
				if (lo.take && lo.valid) begin
					data_q <= lo.data;       // make room: lower entry moves up
				end else if (take) begin
					data_q <= cmd.value;
				end
			end
			OP_SHIFT_DN: data_q <= hi.data;
			default:     data_q <= data_q;
		endcase
	end

endmodule
